// ===== hw/rtl/dmx512_frame_transmitter_core_assert.svh =====
// Assertion macros for the transmitter RTL.
`ifndef DMX512_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define DMX512_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DMXTX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DMXTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dmxtx_pkg.sv =====
// Types and constants of the DMX512 frame transmitter.
package dmxtx_pkg;

    localparam int MAX_CHANNELS = 512;
    localparam int ST_AW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_BITS    = 11;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PW         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);

    localparam int IDX_W = 9;
    localparam int VAL_W = 8;
    localparam int CNT_W = 10;
    localparam int CFG_W = 10;
    localparam int CFG_AW = 2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BREAK_BITS    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MAB_BITS      = 2'd2;

    localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 10'd512;
    localparam logic [7:0]       RST_BREAK_BITS    = 8'd22;
    localparam logic [7:0]       RST_MAB_BITS      = 8'd2;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PH_BREAK = 2'd0,
        PH_MAB   = 2'd1,
        PH_SLOT  = 2'd2
    } t_phase;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_item;

    // Queue head as seen by the sequencer
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // Sequencer status back to the front end
    typedef struct packed {
        logic pop;
        logic clr_busy;
    } t_bk_stat;

endpackage

// ===== hw/rtl/dmx512_frame_transmitter_core.sv =====
// DMX512 frame transmitter: top level.
// Generates a continuous DMX512 line, one result per tick transaction: break
// (low for break_bits periods, frame_start on its first period), mark after
// break (high for mab_bits), start code 0, then channel_count slots of
// start bit, eight data bits LSB first and two stop bits. Write transactions
// (tuser = 1) load one byte into the 512-entry channel store and give no
// result. Throughput is one transaction per clock, ticks and writes alike,
// while the output is not stalled; a tick's result is offered once its
// item has moved from the item queue into the output register. The store
// is a RAM with a write port and a separate registered read port that
// continuously tracks the current slot, so the next slot byte is ready when
// a slot closes. After reset a clearing pass zeroes all 512 store entries,
// one entry per cycle, during which s_tready stays low; config writes are
// taken as usual. Config is expected to be written only while idle.
module dmx512_frame_transmitter_core
    import dmxtx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Config write port: 0 channel_count, 1 break_bits, 2 mab_bits
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,  // [8:0] channel_index, [16:9] channel_value, zero pad
    input  logic              i_s_tuser,  // [0] cmd
    // Output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,  // [0] line_level, zero pad
    output logic              o_m_tuser   // [0] frame_start
);

    t_q_head  head;
    t_bk_stat stat;
    logic     level;

    // Front end: takes transactions, decodes cmd, buffers two items
    dmxtx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata[IDX_W+VAL_W-1:0]),
        .i_s_tuser  (i_s_tuser),
        .i_stat     (stat),
        .o_head     (head)
    );

    // Back end: frame sequencer, channel store, output register
    dmxtx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_head        (head),
        .o_stat        (stat),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_level       (level),
        .o_frame_start (o_m_tuser)
    );

    assign o_m_tdata = {7'b0, level};

endmodule

// ===== hw/rtl/dmxtx_front.sv =====
// Input acceptance, command decode and item queue.
module dmxtx_front
    import dmxtx_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IDX_W+VAL_W-1:0] i_s_tdata,  // channel_index, channel_value
    input  logic                   i_s_tuser,  // cmd
    input  t_bk_stat               i_stat,
    output t_q_head                o_head
);

    t_item            r_q [Q_DEPTH];
    logic [Q_PW-1:0]  r_wp, n_wp;
    logic [Q_PW-1:0]  r_rp, n_rp;
    logic [Q_CW-1:0]  r_cnt, n_cnt;
    logic             push;
    t_item            in_item;

    assign o_s_tready = (r_cnt < Q_CW'(Q_DEPTH)) && !i_stat.clr_busy;
    assign push       = i_s_tvalid && o_s_tready;

    always_comb begin
        in_item.cmd = i_s_tuser ? CMD_WRITE : CMD_TICK;
        in_item.idx = i_s_tdata[IDX_W-1:0];
        in_item.val = i_s_tdata[IDX_W+VAL_W-1:IDX_W];
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_PW'(1);
        end
        if (i_stat.pop) begin
            n_rp = (r_rp == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_PW'(1);
        end
        case ({push, i_stat.pop})
            2'b10:   n_cnt = r_cnt + Q_CW'(1);
            2'b01:   n_cnt = r_cnt - Q_CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

// ===== hw/rtl/dmxtx_back.sv =====
// Frame sequencer, channel store and output register.
module dmxtx_back
    import dmxtx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  t_q_head           i_head,
    output t_bk_stat          o_stat,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic              o_level,
    output logic              o_frame_start
);

    `include "dmx512_frame_transmitter_core_assert.svh"

    // Config
    logic [CNT_W-1:0] r_chan_cnt;
    logic [7:0]       r_break_bits;
    logic [7:0]       r_mab_bits;

    // Sequencer state
    t_phase           r_phase, n_phase;
    logic [7:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic [7:0]       r_shift, n_shift;

    // Store and clear sweep
    logic [VAL_W-1:0] r_store [MAX_CHANNELS];
    logic [VAL_W-1:0] r_rd;
    logic             r_clr_busy;
    logic [ST_AW-1:0] r_clr_addr;
    logic             mem_we;
    logic [ST_AW-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;

    // Output register
    logic r_out_valid;
    logic r_out_level, n_out_level;
    logic r_out_fs, n_out_fs;

    logic             out_free;
    logic             pop, tick_pop, wr_pop;
    logic [CNT_W-1:0] eff_cnt;
    logic [7:0]       cnt_inc;
    logic [7:0]       len;
    logic             slot_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt   <= RST_CHANNEL_COUNT;
            r_break_bits <= RST_BREAK_BITS;
            r_mab_bits   <= RST_MAB_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHANNEL_COUNT: r_chan_cnt   <= i_cfg_wdata[CNT_W-1:0];
                REG_BREAK_BITS:    r_break_bits <= i_cfg_wdata[7:0];
                REG_MAB_BITS:      r_mab_bits   <= i_cfg_wdata[7:0];
                default:           ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign pop      = i_head.valid && !r_clr_busy
                      && ((i_head.item.cmd == CMD_WRITE) || out_free);
    assign tick_pop = pop && (i_head.item.cmd == CMD_TICK);
    assign wr_pop   = pop && (i_head.item.cmd == CMD_WRITE);

    assign o_stat.pop      = pop;
    assign o_stat.clr_busy = r_clr_busy;

    assign eff_cnt   = (r_chan_cnt > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : r_chan_cnt;
    assign cnt_inc   = r_cnt + 8'd1;
    assign slot_last = (r_slot >= eff_cnt);

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_shift     = r_shift;
        n_out_level = 1'b1;
        n_out_fs    = 1'b0;
        len         = 8'd1;
        case (r_phase)
            PH_MAB: begin
                len         = (r_mab_bits != 8'd0) ? r_mab_bits : 8'd1;
                n_out_level = 1'b1;
                n_cnt       = cnt_inc;
                if (cnt_inc >= len) begin
                    n_phase = PH_SLOT;
                    n_cnt   = '0;
                    n_slot  = '0;
                    n_shift = '0;
                end
            end
            PH_SLOT: begin
                if (r_cnt == 8'd0) begin
                    n_out_level = 1'b0;
                end else if (r_cnt <= 8'd8) begin
                    n_out_level = r_shift[0];
                    n_shift     = {1'b0, r_shift[7:1]};
                end else begin
                    n_out_level = 1'b1;
                end
                n_cnt = cnt_inc;
                if (cnt_inc >= 8'(SLOT_BITS)) begin
                    n_cnt = '0;
                    if (slot_last) begin
                        n_phase = PH_BREAK;
                        n_slot  = '0;
                    end else begin
                        n_slot  = r_slot + CNT_W'(1);
                        // r_rd already holds the byte of the slot being closed
                        n_shift = r_rd;
                    end
                end
            end
            default: begin
                len         = (r_break_bits != 8'd0) ? r_break_bits : 8'd1;
                n_phase     = PH_BREAK;
                n_out_level = 1'b0;
                n_out_fs    = (r_cnt == 8'd0);
                n_cnt       = cnt_inc;
                if (cnt_inc >= len) begin
                    n_phase = PH_MAB;
                    n_cnt   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BREAK;
            r_cnt   <= '0;
            r_slot  <= '0;
            r_shift <= '0;
        end else if (tick_pop) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_pop) begin
            r_out_level <= n_out_level;
            r_out_fs    <= n_out_fs;
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_level       = r_out_level;
    assign o_frame_start = r_out_fs;

    // Clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ST_AW'(1);
            if (r_clr_addr == ST_AW'(MAX_CHANNELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_pop && (32'(i_head.item.idx) < 32'(MAX_CHANNELS));
            mem_waddr = ST_AW'(i_head.item.idx);
            mem_wdata = i_head.item.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
    end

    // Read port follows the current slot; a write to that entry is bypassed
    always_ff @(posedge i_clk) begin
        if (mem_we && (mem_waddr == r_slot[ST_AW-1:0])) begin
            r_rd <= mem_wdata;
        end else begin
            r_rd <= r_store[r_slot[ST_AW-1:0]];
        end
    end

    `DMXTX_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_clr_busy, !pop, "item taken during clear")
    `DMXTX_ASSERT_NOW(a_no_out_overrun, i_clk, i_rst_n, r_out_valid && !i_m_tready, !tick_pop, "result overwritten while stalled")
    `DMXTX_ASSERT_NEXT(a_slot_load, i_clk, i_rst_n, tick_pop && (r_phase == PH_SLOT) && (r_cnt == 8'(SLOT_BITS - 1)) && !slot_last, r_shift == $past(r_rd), "slot byte not loaded")

endmodule
